/* sv/press_to_response_latency_meter_unit_macros.svh */
// assertion helpers for the latency meter checker
`ifndef PRESS_TO_RESPONSE_LATENCY_METER_UNIT_MACROS_SVH
`define PRESS_TO_RESPONSE_LATENCY_METER_UNIT_MACROS_SVH

// same-cycle implication, held off during reset
`define PTRLM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("latency meter check failed");

// next-cycle implication, held off during reset
`define PTRLM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("latency meter check failed");

`endif

/* sv/ptrlm_pkg.sv */
`default_nettype none
package ptrlm_pkg;

  localparam int HistDepth = 50;
  localparam int SlotW     = (HistDepth > 1) ? $clog2(HistDepth) : 1;
  localparam int CntW      = $clog2(HistDepth + 1);
  localparam int LagW      = 20;
  localparam int SumW      = LagW + CntW;
  localparam int DivCntW   = $clog2(SumW);
  localparam int TimeW     = 32;
  localparam int WordW     = 32;
  localparam int ModeW     = 2;
  localparam int CfgW      = 32;
  localparam int CfgIdxW   = 2;

  localparam logic [LagW-1:0]  TimeoutReset  = LagW'(400000);
  localparam logic [LagW-1:0]  TrustGapReset = LagW'(5000);
  localparam logic [WordW-1:0] MaskReset     = '1;

  typedef enum logic [ModeW-1:0] {
    MODE_TICK  = 2'd0,
    MODE_IDLE  = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TIMEOUT   = 2'd0,
    REG_TRUST_GAP = 2'd1,
    REG_RESP_MASK = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_APPLY,
    ST_DIV,
    ST_DONE
  } state_t;

  // first field in the highest bits
  typedef struct packed {
    logic [WordW-1:0] watched_word;
    logic             word_valid;
    logic             press_seen;
    logic             foreground;
    logic [TimeW-1:0] time_us;
  } item_t;

  typedef struct packed {
    logic            armed;
    logic [CntW-1:0] trusted_total;
    logic            average_valid;
    logic [LagW-1:0] average_us;
    logic            last_valid;
    logic [LagW-1:0] last_lag_us;
    logic            recorded;
  } result_t;

  localparam int ItemW   = $bits(item_t);
  localparam int ResultW = $bits(result_t);
  localparam int InDataW  = ((ItemW + 7) / 8) * 8;
  localparam int OutDataW = ((ResultW + 7) / 8) * 8;

  typedef struct packed {
    logic load;
    logic calc;
    logic apply;
    logic div_step;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_last;
  } dp_status_t;

endpackage
`default_nettype wire

/* sv/ptrlm_ctrl.sv */
`default_nettype none
module ptrlm_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_valid,
  output logic                        s_ready,
  output logic                        m_valid,
  input  wire logic                   m_ready,
  input  wire ptrlm_pkg::dp_status_t  status,
  output ptrlm_pkg::ctrl_cmd_t        cmd
);

  ptrlm_pkg::state_t state, state_next;
  logic out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ptrlm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ptrlm_pkg::ST_IDLE:  if (s_valid) state_next = ptrlm_pkg::ST_CALC;
      ptrlm_pkg::ST_CALC:  state_next = ptrlm_pkg::ST_APPLY;
      ptrlm_pkg::ST_APPLY: state_next = ptrlm_pkg::ST_DIV;
      ptrlm_pkg::ST_DIV:   if (status.div_last) state_next = ptrlm_pkg::ST_DONE;
      ptrlm_pkg::ST_DONE:  if (!out_valid || m_ready) state_next = ptrlm_pkg::ST_IDLE;
      default:             state_next = ptrlm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd     = '0;
    s_ready = 1'b0;
    case (state)
      ptrlm_pkg::ST_IDLE: begin
        s_ready  = 1'b1;
        cmd.load = s_valid;
      end
      ptrlm_pkg::ST_CALC:  cmd.calc = 1'b1;
      ptrlm_pkg::ST_APPLY: cmd.apply = 1'b1;
      ptrlm_pkg::ST_DIV:   cmd.div_step = 1'b1;
      ptrlm_pkg::ST_DONE:  cmd.out_load = !out_valid || m_ready;
      default: ;
    endcase
  end

  // result register handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (m_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign m_valid = out_valid;

endmodule
`default_nettype wire

/* sv/ptrlm_dp.sv */
`default_nettype none
module ptrlm_dp (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [ptrlm_pkg::CfgIdxW-1:0]       cfg_index,
  input  wire logic [ptrlm_pkg::CfgW-1:0]          cfg_data,
  input  wire logic [ptrlm_pkg::ModeW-1:0]         mode_in,
  input  wire ptrlm_pkg::item_t                    item_in,
  input  wire ptrlm_pkg::ctrl_cmd_t                cmd,
  output ptrlm_pkg::dp_status_t                    status,
  output ptrlm_pkg::result_t                       result
);

  localparam int LagW  = ptrlm_pkg::LagW;
  localparam int CntW  = ptrlm_pkg::CntW;
  localparam int SumW  = ptrlm_pkg::SumW;
  localparam int SlotW = ptrlm_pkg::SlotW;
  localparam int TimeW = ptrlm_pkg::TimeW;
  localparam int WordW = ptrlm_pkg::WordW;

  // configuration
  logic [LagW-1:0]  timeout_us;
  logic [LagW-1:0]  trust_gap_us;
  logic [WordW-1:0] response_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_us    <= ptrlm_pkg::TimeoutReset;
      trust_gap_us  <= ptrlm_pkg::TrustGapReset;
      response_mask <= ptrlm_pkg::MaskReset;
    end else if (cfg_we) begin
      case (ptrlm_pkg::cfg_reg_t'(cfg_index))
        ptrlm_pkg::REG_TIMEOUT:   timeout_us    <= cfg_data[LagW-1:0];
        ptrlm_pkg::REG_TRUST_GAP: trust_gap_us  <= cfg_data[LagW-1:0];
        ptrlm_pkg::REG_RESP_MASK: response_mask <= cfg_data[WordW-1:0];
        default: ;
      endcase
    end
  end

  // measurement state
  logic [SlotW-1:0] write_slot, write_slot_next;
  logic [CntW-1:0]  held_count, held_count_next;
  logic [SumW-1:0]  trusted_sum, trusted_sum_next;
  logic [CntW-1:0]  trusted_held, trusted_held_next;
  logic [LagW-1:0]  last_lag, last_lag_next;
  logic             last_present, last_present_next;
  logic             waiting, waiting_next;
  logic [TimeW-1:0] press_stamp, press_stamp_next;
  logic [LagW-1:0]  worst_gap, worst_gap_next;
  logic [TimeW-1:0] prior_tick_stamp, prior_tick_stamp_next;
  logic             prior_tick_present, prior_tick_present_next;
  logic [WordW-1:0] prior_word, prior_word_next;
  logic             prior_word_present, prior_word_present_next;
  logic             recorded, recorded_next;

  // latched request and ring entry about to be overwritten
  logic [ptrlm_pkg::ModeW-1:0] mode_q;
  ptrlm_pkg::item_t            item_q;
  logic [LagW:0]               ring [ptrlm_pkg::HistDepth];
  logic [LagW:0]               old_entry;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q    <= mode_in;
      item_q    <= item_in;
      old_entry <= ring[write_slot];
    end
  end

  // first step: gap, elapsed time and word change
  logic [TimeW-1:0] gap_raw;
  logic [LagW-1:0]  gap_sat;
  logic [TimeW-1:0] elapsed;
  logic [WordW-1:0] masked;
  logic [LagW-1:0]  gap_q;
  logic [LagW-1:0]  lag_q;
  logic             elapsed_ok_q;
  logic             changed_q;
  logic [WordW-1:0] masked_q;

  always_comb begin
    gap_raw = item_q.time_us - prior_tick_stamp;
    if (!prior_tick_present) begin
      gap_sat = '0;
    end else if (|gap_raw[TimeW-1:LagW]) begin
      gap_sat = '1;
    end else begin
      gap_sat = gap_raw[LagW-1:0];
    end
    elapsed = item_q.time_us - press_stamp;
    masked  = item_q.watched_word & response_mask;
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      gap_q        <= gap_sat;
      lag_q        <= elapsed[LagW-1:0];
      elapsed_ok_q <= elapsed <= {{(TimeW-LagW){1'b0}}, timeout_us};
      changed_q    <= prior_word_present && (masked != prior_word);
      masked_q     <= masked;
    end
  end

  // second step: state update
  logic [LagW-1:0] worst_eff;
  logic            trusted_new;
  logic            evict;
  logic            store;

  always_comb begin
    worst_eff   = (waiting && gap_q > worst_gap) ? gap_q : worst_gap;
    trusted_new = worst_eff <= trust_gap_us;
    evict       = (held_count >= CntW'(ptrlm_pkg::HistDepth)) && old_entry[LagW];

    write_slot_next         = write_slot;
    held_count_next         = held_count;
    trusted_sum_next        = trusted_sum;
    trusted_held_next       = trusted_held;
    last_lag_next           = last_lag;
    last_present_next       = last_present;
    waiting_next            = waiting;
    press_stamp_next        = press_stamp;
    worst_gap_next          = worst_gap;
    prior_tick_stamp_next   = prior_tick_stamp;
    prior_tick_present_next = prior_tick_present;
    prior_word_next         = prior_word;
    prior_word_present_next = prior_word_present;
    store                   = 1'b0;

    case (ptrlm_pkg::mode_t'(mode_q))
      ptrlm_pkg::MODE_TICK: begin
        prior_tick_stamp_next   = item_q.time_us;
        prior_tick_present_next = 1'b1;
        if (!item_q.foreground) begin
          waiting_next            = 1'b0;
          prior_word_present_next = 1'b0;
        end else begin
          worst_gap_next = worst_eff;
          if (item_q.word_valid) begin
            prior_word_present_next = 1'b1;
            prior_word_next         = masked_q;
            if (changed_q) begin
              store        = waiting && elapsed_ok_q;
              waiting_next = 1'b0;
            end
          end
          if (item_q.press_seen) begin
            waiting_next     = 1'b1;
            press_stamp_next = item_q.time_us;
            worst_gap_next   = '0;
          end else if (!elapsed_ok_q) begin
            waiting_next = 1'b0;
          end
        end
      end
      ptrlm_pkg::MODE_IDLE: begin
        waiting_next            = 1'b0;
        prior_word_present_next = 1'b0;
        prior_tick_present_next = 1'b0;
      end
      ptrlm_pkg::MODE_CLEAR: begin
        write_slot_next   = '0;
        held_count_next   = '0;
        trusted_sum_next  = '0;
        trusted_held_next = '0;
        last_lag_next     = '0;
        last_present_next = 1'b0;
      end
      default: ;
    endcase

    recorded_next = store;
    if (store) begin
      // drop the overwritten sample from the sums once the ring is full
      trusted_sum_next = trusted_sum
                         - (evict ? {{CntW{1'b0}}, old_entry[LagW-1:0]} : '0)
                         + (trusted_new ? {{CntW{1'b0}}, lag_q} : '0);
      trusted_held_next = trusted_held - {{(CntW-1){1'b0}}, evict}
                          + {{(CntW-1){1'b0}}, trusted_new};
      write_slot_next = (write_slot == SlotW'(ptrlm_pkg::HistDepth - 1)) ?
                        '0 : write_slot + 1'b1;
      if (held_count < CntW'(ptrlm_pkg::HistDepth)) begin
        held_count_next = held_count + 1'b1;
      end
      last_lag_next     = lag_q;
      last_present_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply && store) begin
      ring[write_slot] <= {trusted_new, lag_q};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot         <= '0;
      held_count         <= '0;
      trusted_sum        <= '0;
      trusted_held       <= '0;
      last_lag           <= '0;
      last_present       <= 1'b0;
      waiting            <= 1'b0;
      press_stamp        <= '0;
      worst_gap          <= '0;
      prior_tick_stamp   <= '0;
      prior_tick_present <= 1'b0;
      prior_word         <= '0;
      prior_word_present <= 1'b0;
      recorded           <= 1'b0;
    end else if (cmd.apply) begin
      write_slot         <= write_slot_next;
      held_count         <= held_count_next;
      trusted_sum        <= trusted_sum_next;
      trusted_held       <= trusted_held_next;
      last_lag           <= last_lag_next;
      last_present       <= last_present_next;
      waiting            <= waiting_next;
      press_stamp        <= press_stamp_next;
      worst_gap          <= worst_gap_next;
      prior_tick_stamp   <= prior_tick_stamp_next;
      prior_tick_present <= prior_tick_present_next;
      prior_word         <= prior_word_next;
      prior_word_present <= prior_word_present_next;
      recorded           <= recorded_next;
    end
  end

  // restoring divider, one quotient bit per cycle, dividend shifts out of quo
  logic [SumW-1:0]                  quo;
  logic [CntW:0]                    rem;
  logic [ptrlm_pkg::DivCntW-1:0]    div_cnt;
  logic [CntW:0]                    rem_shift;
  logic                             rem_ge;

  always_comb begin
    rem_shift = {rem[CntW-1:0], quo[SumW-1]};
    rem_ge    = rem_shift >= {1'b0, trusted_held};
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      quo     <= trusted_sum_next;
      rem     <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      quo     <= {quo[SumW-2:0], rem_ge};
      rem     <= rem_ge ? rem_shift - {1'b0, trusted_held} : rem_shift;
      div_cnt <= div_cnt + 1'b1;
    end
  end

  assign status.div_last = div_cnt == ptrlm_pkg::DivCntW'(SumW - 1);

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result.recorded      <= recorded;
      result.last_lag_us   <= last_present ? last_lag : '0;
      result.last_valid    <= last_present;
      result.average_us    <= (trusted_held != '0) ? quo[LagW-1:0] : '0;
      result.average_valid <= trusted_held != '0;
      result.trusted_total <= trusted_held;
      result.armed         <= waiting;
    end
  end

endmodule
`default_nettype wire

/* sv/press_to_response_latency_meter_unit.sv */
// Press-to-response latency meter. Each request on the s_axis side is one tick
// (tuser selects sampling tick, sampler idle or clear history) and yields exactly
// one result on the m_axis side. A press arms a measurement; the first change of
// the masked watched word within timeout_us records the latency into a ring of
// 50 samples, trusted when the worst tick gap while armed stayed within
// trust_gap_us. The result carries the last latency, the truncated mean of the
// trusted samples and their count. One request is in work at a time. On its way from
// accept to a loaded result register, IDLE takes the request and reads the
// ring, CALC and APPLY update the state, DIV runs the bit-serial divider that
// forms the mean, and DONE loads the result. The divider loop sets the rate.
// The result register lets the next request be taken while a result waits.
// Configuration writes (cfg_we, cfg_index, cfg_data) belong in idle periods.
`default_nettype none
module press_to_response_latency_meter_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // time_us[31:0], foreground[32], press_seen[33], word_valid[34],
  // watched_word[66:35], zero fill above
  input  wire logic [ptrlm_pkg::InDataW-1:0]       s_axis_tdata,
  // mode[1:0]
  input  wire logic [ptrlm_pkg::ModeW-1:0]         s_axis_tuser,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // recorded[0], last_lag_us[20:1], last_valid[21], average_us[41:22],
  // average_valid[42], trusted_total[48:43], armed[49], zero fill above
  output logic [ptrlm_pkg::OutDataW-1:0]           m_axis_tdata,
  input  wire logic                                cfg_we,
  input  wire logic [ptrlm_pkg::CfgIdxW-1:0]       cfg_index,
  input  wire logic [ptrlm_pkg::CfgW-1:0]          cfg_data
);

  ptrlm_pkg::ctrl_cmd_t  cmd;
  ptrlm_pkg::dp_status_t status;
  ptrlm_pkg::result_t    result;
  ptrlm_pkg::item_t      item;

  assign item = ptrlm_pkg::item_t'(s_axis_tdata[ptrlm_pkg::ItemW-1:0]);

  ptrlm_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .m_valid (m_axis_tvalid),
    .m_ready (m_axis_tready),
    .status  (status),
    .cmd     (cmd)
  );

  ptrlm_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mode_in   (s_axis_tuser),
    .item_in   (item),
    .cmd       (cmd),
    .status    (status),
    .result    (result)
  );

  assign m_axis_tdata = {{(ptrlm_pkg::OutDataW - ptrlm_pkg::ResultW){1'b0}}, result};

endmodule
`default_nettype wire

/* sv/ptrlm_checker.sv */
`default_nettype none
`include "press_to_response_latency_meter_unit_macros.svh"
module ptrlm_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            s_axis_tvalid,
  input wire logic                            s_axis_tready,
  input wire logic                            m_axis_tvalid,
  input wire logic                            m_axis_tready,
  input wire logic [ptrlm_pkg::OutDataW-1:0]  m_axis_tdata
);

  // a stalled result holds its payload
  `PTRLM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))

  // one request in work at a time
  `PTRLM_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // mean is flagged exactly when trusted samples are held, and reads zero otherwise
  `PTRLM_ASSERT_NOW(a_avg_flag, m_axis_tvalid, (m_axis_tdata[42] == (m_axis_tdata[48:43] != 6'd0)) && (m_axis_tdata[42] || (m_axis_tdata[41:22] == 20'd0)))

  // a fresh sample means a last latency exists
  `PTRLM_ASSERT_NOW(a_recorded_last, m_axis_tvalid && m_axis_tdata[0], m_axis_tdata[21])

  // trusted count never exceeds the ring depth
  `PTRLM_ASSERT_NOW(a_total_range, m_axis_tvalid, m_axis_tdata[48:43] <= 6'd50)

endmodule

bind press_to_response_latency_meter_unit ptrlm_checker u_ptrlm_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
